// File: sv/bpa_pkg.sv
package bpa_pkg;

  localparam int PAGE_COUNT = 4096;
  localparam int TOP_ORDER  = 9;
  localparam int PAGE_SHIFT = 12;

  localparam int PAGE_BITS  = $clog2(PAGE_COUNT);
  localparam int LINK_W     = PAGE_BITS + 1;
  localparam int ORDERS     = TOP_ORDER + 1;
  localparam int ORD_W      = 4;
  localparam int ADDR_W     = 40;
  localparam int TOP_SIZE   = 1 << TOP_ORDER;
  localparam int IN_W       = 48;
  localparam int OUT_W      = 56;

  localparam logic [LINK_W-1:0] NIL = LINK_W'(PAGE_COUNT);

  typedef enum logic [1:0] {
    ST_DONE   = 2'd0,
    ST_NOMEM  = 2'd1,
    ST_REJECT = 2'd2
  } result_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_CLEAR,
    OP_LOAD,
    OP_SCAN,
    OP_HEAD_RD,
    OP_SPLIT_POP,
    OP_SPLIT_LOW,
    OP_SPLIT_HIGH,
    OP_LINK,
    OP_POP,
    OP_F_CHECK,
    OP_F_USED,
    OP_M_RD,
    OP_M_TEST,
    OP_PUSH,
    OP_REJECT,
    OP_NOMEM,
    OP_OUT
  } op_t;

  typedef struct packed {
    logic clr_last;
    logic ord_bad;
    logic hit;
    logic top;
    logic more;
    logic free_bad;
    logic used_bit;
    logic o_top;
    logic merge_ok;
  } status_t;

  typedef enum logic [4:0] {
    S_INIT,
    S_IDLE,
    S_SCAN,
    S_S_READ,
    S_S_POP,
    S_S_LOW,
    S_S_HIGH,
    S_S_LINK,
    S_P_READ,
    S_P_POP,
    S_F_CHECK,
    S_F_READ,
    S_M_READ,
    S_M_TEST,
    S_U_PUSH,
    S_U_LINK,
    S_REJECT,
    S_NOMEM,
    S_FINISH
  } state_t;

endpackage

// File: sv/buddy_page_allocator_unit.sv
// buddy page allocator: 4096 pages, orders 0..9, one lifo free list per order.
// after reset a clearing pass (one page per cycle) loads the page tables; no
// request is taken until it ends, config writes are taken. one request is
// worked at a time. an allocate loads the request, scans the lists upward
// from its order (rejecting a bad order, reporting no memory when all are
// empty), and per split level reads and pops the list head, writes the low
// and high halves to the next lower list, relinks it and rescans; it then
// pops the block and hands it off. a free checks the address and the used
// bit (rejecting a bad one), merges with a free buddy one order at a time,
// then pushes and links the block and hands it off. the page tables share one read address and have a registered read.
// a finished result sits in an output register; the next request is taken once it is loaded there.
module buddy_page_allocator_unit (
  input  logic                        clk,
  input  logic                        rst,
  // pool base address
  input  logic                        cfg_we,
  input  logic [bpa_pkg::ADDR_W-1:0]  cfg_wdata,
  // request
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [bpa_pkg::IN_W-1:0]    s_tdata,   // order[3:0], address[43:4]
  input  logic                        s_tuser,   // action: 0 allocate, 1 free
  // result
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [bpa_pkg::OUT_W-1:0]   m_tdata    // status[1:0], block_address[41:2],
                                                 // page_index[53:42]
);

  bpa_pkg::op_t     op;
  bpa_pkg::status_t stat;

  // sequencer for split, merge and list updates
  bpa_ctrl u_ctrl (
    .clk(clk), .rst(rst), .stat(stat),
    .s_tvalid(s_tvalid), .s_tuser(s_tuser), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .op(op)
  );

  // page tables, list heads and result register
  bpa_datapath u_dp (
    .clk(clk), .rst(rst), .op(op),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_tdata(s_tdata),
    .stat(stat), .m_tdata(m_tdata)
  );

endmodule

// File: sv/bpa_ram.sv
module bpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wa,
  input  logic [WIDTH-1:0]         wd,
  input  logic [$clog2(DEPTH)-1:0] ra,
  output logic [WIDTH-1:0]         rd
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd <= mem[ra];
  end

endmodule

// File: sv/bpa_datapath.sv
module bpa_datapath (
  input  logic                            clk,
  input  logic                            rst,
  input  bpa_pkg::op_t                    op,
  input  logic                            cfg_we,
  input  logic [bpa_pkg::ADDR_W-1:0]      cfg_wdata,
  input  logic [bpa_pkg::IN_W-1:0]        s_tdata,
  output bpa_pkg::status_t                stat,
  output logic [bpa_pkg::OUT_W-1:0]       m_tdata
);

  localparam int PB = bpa_pkg::PAGE_BITS;
  localparam int LW = bpa_pkg::LINK_W;
  localparam int OW = bpa_pkg::ORD_W;
  localparam int AW = bpa_pkg::ADDR_W;
  localparam int PS = bpa_pkg::PAGE_SHIFT;
  localparam logic [OW-1:0] TOP = OW'(bpa_pkg::TOP_ORDER);
  localparam logic [LW-1:0] NIL = bpa_pkg::NIL;

  logic [AW-1:0] pool_base;
  logic [OW-1:0] ord, k, o;
  logic [AW-1:0] addr;
  logic [PB-1:0] h, b, lnk, cur, pg, clr;
  logic [LW-1:0] hh;
  logic [1:0]    res_st;
  logic [AW-1:0] res_addr;
  logic [PB-1:0] res_page;
  logic [LW-1:0] head [bpa_pkg::ORDERS];

  logic [OW-1:0] kk, km1;
  logic [LW-1:0] head_k;
  logic [AW-1:0] off;
  logic [PB-1:0] off_pg, buddy, cur_m, split_b;

  // ram ports
  logic          ord_we, used_we, fh_we, nx_we, pv_we;
  logic [PB-1:0] ord_wa, used_wa, fh_wa, nx_wa, pv_wa, ra;
  logic [OW-1:0] ord_wd, ord_rd;
  logic          used_wd, used_rd, fh_wd, fh_rd;
  logic [LW-1:0] nx_wd, nx_rd, pv_wd, pv_rd;

  // reset contents of page clr
  logic          init_fh;
  logic [LW-1:0] init_nx, init_pv;

  assign kk     = (k > TOP) ? TOP : k;
  assign km1    = kk - OW'(1);
  assign head_k = head[kk];
  assign off    = addr - pool_base;
  assign off_pg = off[PS +: PB];
  assign buddy  = cur ^ (PB'(1) << o);
  assign cur_m  = cur & ~(PB'(1) << o);
  assign split_b = h ^ (PB'(1) << km1);

  assign init_fh = (clr[bpa_pkg::TOP_ORDER-1:0] == '0);
  assign init_nx = (init_fh && ({1'b0, clr} >= LW'(bpa_pkg::TOP_SIZE)))
                   ? ({1'b0, clr} - LW'(bpa_pkg::TOP_SIZE)) : NIL;
  assign init_pv = (init_fh && (({1'b0, clr} + LW'(bpa_pkg::TOP_SIZE)) < NIL))
                   ? ({1'b0, clr} + LW'(bpa_pkg::TOP_SIZE)) : NIL;

  always_comb begin
    stat.clr_last = (clr == PB'(bpa_pkg::PAGE_COUNT - 1));
    stat.ord_bad  = (ord > TOP);
    stat.hit      = (head_k != NIL);
    stat.top      = (k == TOP);
    stat.more     = (k > ord);
    stat.free_bad = (addr < pool_base) || (off[PS-1:0] != '0) ||
                    (off[AW-1:PS+PB] != '0);
    stat.used_bit = used_rd;
    stat.o_top    = (o == TOP);
    stat.merge_ok = fh_rd && (ord_rd == o) && !used_rd;
  end

  always_comb begin
    ord_we = 1'b0;  ord_wa = '0;  ord_wd = '0;
    used_we = 1'b0; used_wa = '0; used_wd = 1'b0;
    fh_we = 1'b0;   fh_wa = '0;   fh_wd = 1'b0;
    nx_we = 1'b0;   nx_wa = '0;   nx_wd = '0;
    pv_we = 1'b0;   pv_wa = '0;   pv_wd = '0;
    ra = '0;
    case (op)
      bpa_pkg::OP_CLEAR: begin
        ord_we = 1'b1;  ord_wa = clr;  ord_wd = TOP;
        used_we = 1'b1; used_wa = clr; used_wd = 1'b0;
        fh_we = 1'b1;   fh_wa = clr;   fh_wd = init_fh;
        nx_we = 1'b1;   nx_wa = clr;   nx_wd = init_nx;
        pv_we = 1'b1;   pv_wa = clr;   pv_wd = init_pv;
      end
      bpa_pkg::OP_HEAD_RD: ra = head_k[PB-1:0];
      bpa_pkg::OP_SPLIT_POP: begin
        if (nx_rd != NIL) begin
          pv_we = 1'b1; pv_wa = nx_rd[PB-1:0]; pv_wd = NIL;
        end
      end
      bpa_pkg::OP_SPLIT_LOW: begin
        nx_we = 1'b1;  nx_wa = h;  nx_wd = hh;
        pv_we = 1'b1;  pv_wa = h;  pv_wd = {1'b0, b};
        fh_we = 1'b1;  fh_wa = h;  fh_wd = 1'b1;
        ord_we = 1'b1; ord_wa = h; ord_wd = km1;
      end
      bpa_pkg::OP_SPLIT_HIGH: begin
        nx_we = 1'b1;  nx_wa = b;  nx_wd = {1'b0, h};
        pv_we = 1'b1;  pv_wa = b;  pv_wd = NIL;
        fh_we = 1'b1;  fh_wa = b;  fh_wd = 1'b1;
        ord_we = 1'b1; ord_wa = b; ord_wd = km1;
      end
      bpa_pkg::OP_LINK: begin
        if (hh != NIL) begin
          pv_we = 1'b1; pv_wa = hh[PB-1:0]; pv_wd = {1'b0, lnk};
        end
      end
      bpa_pkg::OP_POP: begin
        if (nx_rd != NIL) begin
          pv_we = 1'b1; pv_wa = nx_rd[PB-1:0]; pv_wd = NIL;
        end
        fh_we = 1'b1;   fh_wa = h;   fh_wd = 1'b0;
        used_we = 1'b1; used_wa = h; used_wd = 1'b1;
      end
      bpa_pkg::OP_F_CHECK: ra = off_pg;
      bpa_pkg::OP_F_USED: begin
        if (used_rd) begin
          used_we = 1'b1; used_wa = pg; used_wd = 1'b0;
        end
      end
      bpa_pkg::OP_M_RD: ra = buddy;
      bpa_pkg::OP_M_TEST: begin
        if (stat.merge_ok) begin
          if (pv_rd != NIL) begin
            nx_we = 1'b1; nx_wa = pv_rd[PB-1:0]; nx_wd = nx_rd;
          end
          if (nx_rd != NIL) begin
            pv_we = 1'b1; pv_wa = nx_rd[PB-1:0]; pv_wd = pv_rd;
          end
          fh_we = 1'b1;  fh_wa = b;      fh_wd = 1'b0;
          ord_we = 1'b1; ord_wa = cur_m; ord_wd = o + OW'(1);
        end
      end
      bpa_pkg::OP_PUSH: begin
        nx_we = 1'b1;  nx_wa = cur;  nx_wd = head[o];
        pv_we = 1'b1;  pv_wa = cur;  pv_wd = NIL;
        fh_we = 1'b1;  fh_wa = cur;  fh_wd = 1'b1;
        ord_we = 1'b1; ord_wa = cur; ord_wd = o;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pool_base <= '0;
      clr       <= '0;
      for (int i = 0; i < bpa_pkg::ORDERS; i++) begin
        head[i] <= (i == bpa_pkg::TOP_ORDER)
                   ? LW'(bpa_pkg::PAGE_COUNT - bpa_pkg::TOP_SIZE) : NIL;
      end
    end else begin
      if (cfg_we) begin
        pool_base <= cfg_wdata;
      end
      case (op)
        bpa_pkg::OP_CLEAR: clr <= clr + PB'(1);
        bpa_pkg::OP_SPLIT_POP: head[kk] <= nx_rd;
        bpa_pkg::OP_SPLIT_HIGH: head[km1] <= {1'b0, b};
        bpa_pkg::OP_POP: head[kk] <= nx_rd;
        bpa_pkg::OP_M_TEST: begin
          if (stat.merge_ok && pv_rd == NIL) begin
            head[o] <= nx_rd;
          end
        end
        bpa_pkg::OP_PUSH: head[o] <= {1'b0, cur};
        default: ;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    case (op)
      bpa_pkg::OP_LOAD: begin
        ord  <= s_tdata[OW-1:0];
        k    <= s_tdata[OW-1:0];
        addr <= s_tdata[OW +: AW];
      end
      bpa_pkg::OP_SCAN: begin
        if (!stat.hit && !stat.top && !stat.ord_bad) begin
          k <= k + OW'(1);
        end
      end
      bpa_pkg::OP_HEAD_RD: h <= head_k[PB-1:0];
      bpa_pkg::OP_SPLIT_POP: begin
        b   <= split_b;
        hh  <= head[km1];
        lnk <= h;
      end
      bpa_pkg::OP_SPLIT_HIGH: k <= km1;
      bpa_pkg::OP_POP: begin
        res_st   <= bpa_pkg::ST_DONE;
        res_addr <= pool_base + {{(AW-PB-PS){1'b0}}, h, {PS{1'b0}}};
        res_page <= h;
      end
      bpa_pkg::OP_F_CHECK: pg <= off_pg;
      bpa_pkg::OP_F_USED: begin
        cur <= pg;
        o   <= (ord_rd > TOP) ? TOP : ord_rd;
      end
      bpa_pkg::OP_M_RD: b <= buddy;
      bpa_pkg::OP_M_TEST: begin
        if (stat.merge_ok) begin
          cur <= cur_m;
          o   <= o + OW'(1);
        end
      end
      bpa_pkg::OP_PUSH: begin
        hh       <= head[o];
        lnk      <= cur;
        res_st   <= bpa_pkg::ST_DONE;
        res_addr <= '0;
        res_page <= pg;
      end
      bpa_pkg::OP_REJECT: begin
        res_st   <= bpa_pkg::ST_REJECT;
        res_addr <= '0;
        res_page <= '0;
      end
      bpa_pkg::OP_NOMEM: begin
        res_st   <= bpa_pkg::ST_NOMEM;
        res_addr <= '0;
        res_page <= '0;
      end
      bpa_pkg::OP_OUT: begin
        m_tdata <= {{(bpa_pkg::OUT_W-2-AW-PB){1'b0}}, res_page, res_addr, res_st};
      end
      default: ;
    endcase
  end

  bpa_ram #(.WIDTH(OW), .DEPTH(bpa_pkg::PAGE_COUNT)) u_order (
    .clk(clk), .we(ord_we), .wa(ord_wa), .wd(ord_wd), .ra(ra), .rd(ord_rd)
  );
  bpa_ram #(.WIDTH(1), .DEPTH(bpa_pkg::PAGE_COUNT)) u_used (
    .clk(clk), .we(used_we), .wa(used_wa), .wd(used_wd), .ra(ra), .rd(used_rd)
  );
  bpa_ram #(.WIDTH(1), .DEPTH(bpa_pkg::PAGE_COUNT)) u_free_head (
    .clk(clk), .we(fh_we), .wa(fh_wa), .wd(fh_wd), .ra(ra), .rd(fh_rd)
  );
  bpa_ram #(.WIDTH(LW), .DEPTH(bpa_pkg::PAGE_COUNT)) u_next (
    .clk(clk), .we(nx_we), .wa(nx_wa), .wd(nx_wd), .ra(ra), .rd(nx_rd)
  );
  bpa_ram #(.WIDTH(LW), .DEPTH(bpa_pkg::PAGE_COUNT)) u_prev (
    .clk(clk), .we(pv_we), .wa(pv_wa), .wd(pv_wd), .ra(ra), .rd(pv_rd)
  );

endmodule

// File: sv/bpa_ctrl.sv
module bpa_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  bpa_pkg::status_t stat,
  input  logic             s_tvalid,
  input  logic             s_tuser,
  output logic             s_tready,
  output logic             m_tvalid,
  input  logic             m_tready,
  output bpa_pkg::op_t     op
);

  bpa_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= bpa_pkg::S_INIT;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (op == bpa_pkg::OP_OUT) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    op         = bpa_pkg::OP_NONE;
    s_tready   = 1'b0;
    unique case (state)
      bpa_pkg::S_INIT: begin
        op = bpa_pkg::OP_CLEAR;
        if (stat.clr_last) state_next = bpa_pkg::S_IDLE;
      end
      bpa_pkg::S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          op = bpa_pkg::OP_LOAD;
          state_next = s_tuser ? bpa_pkg::S_F_CHECK : bpa_pkg::S_SCAN;
        end
      end
      bpa_pkg::S_SCAN: begin
        op = bpa_pkg::OP_SCAN;
        if (stat.ord_bad) state_next = bpa_pkg::S_REJECT;
        else if (stat.hit) state_next = stat.more ? bpa_pkg::S_S_READ : bpa_pkg::S_P_READ;
        else if (stat.top) state_next = bpa_pkg::S_NOMEM;
      end
      bpa_pkg::S_S_READ: begin
        op = bpa_pkg::OP_HEAD_RD;
        state_next = bpa_pkg::S_S_POP;
      end
      bpa_pkg::S_S_POP: begin
        op = bpa_pkg::OP_SPLIT_POP;
        state_next = bpa_pkg::S_S_LOW;
      end
      bpa_pkg::S_S_LOW: begin
        op = bpa_pkg::OP_SPLIT_LOW;
        state_next = bpa_pkg::S_S_HIGH;
      end
      bpa_pkg::S_S_HIGH: begin
        op = bpa_pkg::OP_SPLIT_HIGH;
        state_next = bpa_pkg::S_S_LINK;
      end
      bpa_pkg::S_S_LINK: begin
        op = bpa_pkg::OP_LINK;
        state_next = bpa_pkg::S_SCAN;
      end
      bpa_pkg::S_P_READ: begin
        op = bpa_pkg::OP_HEAD_RD;
        state_next = bpa_pkg::S_P_POP;
      end
      bpa_pkg::S_P_POP: begin
        op = bpa_pkg::OP_POP;
        state_next = bpa_pkg::S_FINISH;
      end
      bpa_pkg::S_F_CHECK: begin
        op = bpa_pkg::OP_F_CHECK;
        state_next = stat.free_bad ? bpa_pkg::S_REJECT : bpa_pkg::S_F_READ;
      end
      bpa_pkg::S_F_READ: begin
        op = bpa_pkg::OP_F_USED;
        state_next = stat.used_bit ? bpa_pkg::S_M_READ : bpa_pkg::S_REJECT;
      end
      bpa_pkg::S_M_READ: begin
        op = bpa_pkg::OP_M_RD;
        state_next = stat.o_top ? bpa_pkg::S_U_PUSH : bpa_pkg::S_M_TEST;
      end
      bpa_pkg::S_M_TEST: begin
        op = bpa_pkg::OP_M_TEST;
        state_next = stat.merge_ok ? bpa_pkg::S_M_READ : bpa_pkg::S_U_PUSH;
      end
      bpa_pkg::S_U_PUSH: begin
        op = bpa_pkg::OP_PUSH;
        state_next = bpa_pkg::S_U_LINK;
      end
      bpa_pkg::S_U_LINK: begin
        op = bpa_pkg::OP_LINK;
        state_next = bpa_pkg::S_FINISH;
      end
      bpa_pkg::S_REJECT: begin
        op = bpa_pkg::OP_REJECT;
        state_next = bpa_pkg::S_FINISH;
      end
      bpa_pkg::S_NOMEM: begin
        op = bpa_pkg::OP_NOMEM;
        state_next = bpa_pkg::S_FINISH;
      end
      bpa_pkg::S_FINISH: begin
        if (!m_tvalid || m_tready) begin
          op = bpa_pkg::OP_OUT;
          state_next = bpa_pkg::S_IDLE;
        end
      end
      default: state_next = bpa_pkg::S_INIT;
    endcase
  end

endmodule

// File: sim/buddy_page_allocator_unit_tb.sv
`timescale 1ns / 1ps

module buddy_page_allocator_unit_tb;

  localparam int PAGE_COUNT = bpa_pkg::PAGE_COUNT;
  localparam int TOP_ORDER  = bpa_pkg::TOP_ORDER;
  localparam int ORDERS     = bpa_pkg::ORDERS;
  localparam int TOP_SIZE   = bpa_pkg::TOP_SIZE;
  localparam int PAGE_SHIFT = bpa_pkg::PAGE_SHIFT;
  localparam int ADDR_W     = bpa_pkg::ADDR_W;
  localparam int IN_W       = bpa_pkg::IN_W;
  localparam int OUT_W      = bpa_pkg::OUT_W;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;
  localparam int LIMIT_CYCLES = 900000;

  // one result of the allocator
  typedef struct {
    bpa_pkg::result_t status;
    logic [39:0]      block_address;
    logic [11:0]      page_index;
    bit               is_alloc;
  } alloc_result_t;

  // shadow allocator and store of expected results
  class alloc_scoreboard;
    logic [39:0] pool_base;
    int unsigned blk_order [PAGE_COUNT];
    bit          blk_used [PAGE_COUNT];
    bit          blk_head [PAGE_COUNT];
    int unsigned nxt [PAGE_COUNT];
    int unsigned prv [PAGE_COUNT];
    int unsigned head [ORDERS];
    alloc_result_t pending [$];
    int errors;

    function void clear_state();
      for (int i = 0; i < PAGE_COUNT; i++) begin
        blk_order[i] = TOP_ORDER;
        blk_used[i] = 0;
        blk_head[i] = 0;
        nxt[i] = PAGE_COUNT;
        prv[i] = PAGE_COUNT;
      end
      for (int k = 0; k < ORDERS; k++) head[k] = PAGE_COUNT;
      for (int i = 0; i + TOP_SIZE <= PAGE_COUNT; i += TOP_SIZE) push(TOP_ORDER, i);
      pool_base = '0;
      errors = 0;
    endfunction

    function void push(int unsigned k, int unsigned x);
      nxt[x] = head[k];
      prv[x] = PAGE_COUNT;
      if (head[k] < PAGE_COUNT) prv[head[k]] = x;
      head[k] = x;
      blk_head[x] = 1;
      blk_order[x] = k;
    endfunction

    function int unsigned pop(int unsigned k);
      int unsigned h;
      h = head[k];
      if (h >= PAGE_COUNT) return PAGE_COUNT;
      head[k] = nxt[h];
      if (nxt[h] < PAGE_COUNT) prv[nxt[h]] = PAGE_COUNT;
      nxt[h] = PAGE_COUNT;
      prv[h] = PAGE_COUNT;
      blk_head[h] = 0;
      return h;
    endfunction

    function void unlink(int unsigned k, int unsigned b);
      if (prv[b] < PAGE_COUNT) nxt[prv[b]] = nxt[b];
      else head[k] = nxt[b];
      if (nxt[b] < PAGE_COUNT) prv[nxt[b]] = prv[b];
      nxt[b] = PAGE_COUNT;
      prv[b] = PAGE_COUNT;
      blk_head[b] = 0;
    endfunction

    // note an accepted request and queue its expected result
    function void note_request(logic act, logic [3:0] ord, logic [39:0] addr);
      alloc_result_t r;
      int unsigned k, x, h, b, cur, o;
      logic [39:0] off;
      r.status = bpa_pkg::ST_REJECT;
      r.block_address = '0;
      r.page_index = '0;
      r.is_alloc = (act == ACT_ALLOC);
      if (act == ACT_ALLOC) begin
        if (ord <= TOP_ORDER) begin
          k = 32'(ord);
          while (k <= TOP_ORDER && head[k] >= PAGE_COUNT) k++;
          r.status = bpa_pkg::ST_NOMEM;
          if (k <= TOP_ORDER) begin
            for (; k > ord; k--) begin
              h = pop(k);
              b = h ^ (1 << (k - 1));
              push(k - 1, h);
              if (b < PAGE_COUNT) push(k - 1, b);
            end
            x = pop(32'(ord));
            if (x < PAGE_COUNT) begin
              blk_used[x] = 1;
              r.status = bpa_pkg::ST_DONE;
              r.block_address = pool_base + (40'(x) << PAGE_SHIFT);
              r.page_index = x[11:0];
            end
          end
        end
      end else if (addr >= pool_base) begin
        off = addr - pool_base;
        if (off[PAGE_SHIFT-1:0] == 0 && (off >> PAGE_SHIFT) < PAGE_COUNT
            && blk_used[off >> PAGE_SHIFT]) begin
          cur = 32'(off >> PAGE_SHIFT);
          r.status = bpa_pkg::ST_DONE;
          r.page_index = cur[11:0];
          blk_used[cur] = 0;
          o = blk_order[cur];
          if (o > TOP_ORDER) o = TOP_ORDER;
          // merge upward while the buddy heads a free block of the same order
          while (o < TOP_ORDER) begin
            b = cur ^ (1 << o);
            if (b >= PAGE_COUNT || !blk_head[b] || blk_order[b] != o || blk_used[b]) break;
            unlink(o, b);
            if (b < cur) cur = b;
            o++;
            blk_order[cur] = o;
          end
          push(o, cur);
        end
      end
      pending.push_back(r);
    endfunction

    // compare one result with the oldest expectation; true for a done allocate
    function bit check_result(logic [OUT_W-1:0] d);
      alloc_result_t e;
      if (pending.size() == 0) begin
        $error("result with nothing expected: %h", d);
        errors++;
        return 0;
      end
      e = pending.pop_front();
      if (d[1:0] != e.status) begin
        $error("status expected %0d actual %0d", e.status, d[1:0]);
        errors++;
      end
      if (d[41:2] != e.block_address) begin
        $error("block_address expected %h actual %h", e.block_address, d[41:2]);
        errors++;
      end
      if (d[53:42] != e.page_index) begin
        $error("page_index expected %0d actual %0d", e.page_index, d[53:42]);
        errors++;
      end
      return e.is_alloc && (e.status == bpa_pkg::ST_DONE);
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [ADDR_W-1:0] cfg_wdata = '0;
  logic s_tvalid = 0;
  logic s_tready;
  logic [IN_W-1:0] s_tdata = '0;
  logic s_tuser = 0;
  logic m_tvalid;
  logic m_tready = 0;
  logic [OUT_W-1:0] m_tdata;

  alloc_scoreboard sb;
  int cycles = 0;
  bit no_idle = 0;        // final stretch runs without any idling
  logic [39:0] live_blocks [$];  // addresses handed out and not yet returned

  always #4 clk = ~clk;

  buddy_page_allocator_unit dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  // timeout watchdog, covers the clearing pass too
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // result side: random stall bursts, check on each accepted result
  initial begin
    int burst;
    burst = 0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) begin
        // remember blocks handed out so later frees can return them
        if (sb.check_result(m_tdata)) live_blocks.push_back(m_tdata[41:2]);
      end
      if (burst > 0) begin
        burst--;
        m_tready <= 0;
      end else if (!no_idle && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(0, 4);
        m_tready <= 0;
      end else m_tready <= 1;
    end
  end

  // one request; waits for acceptance, random idle burst before it
  task automatic send_request(logic act, logic [3:0] ord, logic [39:0] addr);
    int gap;
    if (!no_idle && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 5);
      s_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1;
    s_tuser <= act;
    s_tdata <= {4'b0, addr, ord};
    do @(posedge clk); while (!s_tready);
    sb.note_request(act, ord, addr);
  endtask

  task automatic go_idle();
    s_tvalid <= 0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_base(logic [39:0] v);
    cfg_we <= 1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 0;
    sb.pool_base = v;
    live_blocks.delete();
  endtask

  task automatic free_random_live();
    int i;
    logic [39:0] a;
    i = $urandom_range(0, live_blocks.size() - 1);
    a = live_blocks[i];
    live_blocks.delete(i);
    send_request(ACT_FREE, 4'($urandom), a);
  endtask

  // random phase: mostly well-formed alloc/free with some noise
  task automatic random_phase(int n);
    logic [39:0] a;
    int sel;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 45) send_request(ACT_ALLOC, 4'($urandom_range(0, 4) == 0 ?
                                 $urandom_range(0, 15) : $urandom_range(0, 3)),
                                 40'({$urandom, $urandom}));
      else if (sel < 88 && live_blocks.size() > 0) free_random_live();
      else begin
        case ($urandom_range(0, 3))
          0: a = 40'({$urandom, $urandom});
          1: a = sb.pool_base + (40'($urandom_range(0, 4200)) << PAGE_SHIFT);
          2: a = sb.pool_base + 40'($urandom_range(1, 4095));
          default: a = sb.pool_base - 40'($urandom_range(1, 8192));
        endcase
        send_request(ACT_FREE, 4'($urandom), a);
      end
    end
  endtask

  initial begin
    sb = new();
    sb.clear_state();
    repeat (7) @(posedge clk);
    rst <= 0;
    // config write during the clearing pass is allowed
    write_base(40'h00_0000_0000);

    // directed: all orders, oversize orders, bad frees, exhaustion
    for (int k = 0; k <= 15; k++) send_request(ACT_ALLOC, 4'(k), '1);
    send_request(ACT_FREE, 4'd0, 40'hFF_FFFF_F000);
    send_request(ACT_FREE, 4'd0, 40'h00_0000_0801);
    send_request(ACT_FREE, 4'd0, 40'h00_0100_0000);
    send_request(ACT_FREE, 4'd15, 40'h00_0000_1000);
    // drain the pool with top-order allocations, then hit exhaustion
    for (int k = 0; k < 8; k++) send_request(ACT_ALLOC, 4'd9, '0);
    go_idle();
    while (live_blocks.size() > 0) free_random_live();
    go_idle();

    write_base(40'hFF_FFFF_F000);
    random_phase(300);
    go_idle();
    write_base(40'h12_3456_7000);
    random_phase(400);
    // sender holds off until every result has come
    go_idle();
    write_base(40'h00_0000_0000);
    random_phase(400);
    go_idle();
    write_base(40'hFF_0000_0000);
    random_phase(250);
    no_idle = 1;
    random_phase(150);
    s_tvalid <= 0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (sb.errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end
endmodule

// File: sim.f
sv/bpa_pkg.sv
sv/bpa_ram.sv
sv/bpa_datapath.sv
sv/bpa_ctrl.sv
sv/buddy_page_allocator_unit.sv
sim/buddy_page_allocator_unit_tb.sv
